/* src/mspa_pkg.sv */
// ----------------------------------------------------------------------------
// mspa_pkg
// shared types, constants and arithmetic helpers of the pair accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package mspa_pkg;

    localparam int NUM_W     = 6;
    localparam int NUM_SUMS  = 7;
    localparam int ATOM_W    = 8;
    localparam int DIST_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int ENTRY_W   = NUM_W * WEIGHT_W;
    localparam int WPROD_W   = 32;
    localparam int SUM_W     = 64;
    localparam int OUT_W     = 48;
    localparam int SC_W      = 27;
    localparam int QW        = 26;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_LOAD   = 2'd0;
    localparam func_t FUNC_PAIR   = 2'd1;
    localparam func_t FUNC_FINISH = 2'd2;

    localparam logic [29:0] INV_TWO_PI = 30'd683565276;
    localparam logic [30:0] HALF_PI    = 31'd1686629713;
    localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
    localparam logic signed [SC_W-1:0] SINC_ONE = 27'sd65536;
    localparam logic signed [WPROD_W-1:0] PLAIN_WEIGHT = 32'sd1048576;

    typedef struct packed {
        logic                            finish;
        logic [DIST_W-1:0]               distance;
        logic [NUM_W-1:0][WPROD_W-1:0]   wprod;
    } cmd_t;

    typedef logic [NUM_SUMS-1:0][SUM_W-1:0] row_t;
    typedef logic [NUM_SUMS-1:0][OUT_W-1:0] res_t;

    // horner divisors, innermost first
    function automatic logic [6:0] div_const(input logic [1:0] idx);
        logic [6:0] d;
        unique case (idx)
            2'd0: d = 7'd72;
            2'd1: d = 7'd42;
            2'd2: d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] recip_const(input logic [1:0] idx);
        logic [31:0] m;
        unique case (idx)
            2'd0: m = 32'd59652323;
            2'd1: m = 32'd102261126;
            2'd2: m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
        begin
            s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return s;
    endfunction

    function automatic logic [OUT_W-1:0] to_thousandths(input logic [SUM_W-1:0] v);
        logic        neg;
        logic [63:0] m;
        logic [37:0] hi;
        logic [45:0] lo;
        logic [48:0] res;
        logic [OUT_W-1:0] o;
        neg = v[SUM_W-1];
        m   = neg ? (64'd0 - v) : v;
        hi  = 38'(m[63:36]) * 38'd1000;
        lo  = 46'(m[35:0]) * 46'd1000 + 46'h08_0000_0000;
        res = 49'(hi) + 49'(lo[45:36]);
        if (neg)
        begin
            o = (res > 49'h0_8000_0000_0000) ? 48'h8000_0000_0000 : 48'(49'd0 - res);
        end
        else
        begin
            o = (res > 49'h0_7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : res[47:0];
        end
        return o;
    endfunction

endpackage

`default_nettype wire

/* src/mspa_front.sv */
// ----------------------------------------------------------------------------
// mspa_front
// takes input beats, keeps the atom weight table, forms weight products
// ----------------------------------------------------------------------------
`default_nettype none

module mspa_front #(
    parameter int MAX_ATOMS = 256
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [1:0]                   func,
    input  wire  [7:0]                   atom_a,
    input  wire  [7:0]                   atom_b,
    input  wire  [15:0]                  distance,
    input  wire  [mspa_pkg::ENTRY_W-1:0] weights,
    output mspa_pkg::cmd_t               cmd,
    output logic                         push,
    input  wire                          q_full
);
    import mspa_pkg::*;

    localparam int AW = $clog2(MAX_ATOMS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [2:0]         k_reg, k_next;
    logic [ENTRY_W-1:0] wmem [MAX_ATOMS];
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg;
    cmd_t               cmd_reg;
    logic               accept, a_ok, b_ok, wr_en, rd_en;
    logic [AW-1:0]      addr_a, addr_b;
    logic signed [WEIGHT_W-1:0] wa, wb;
    logic signed [WPROD_W-1:0]  wprod;

    assign busy   = (state_reg != F_IDLE);
    assign accept = start && (state_reg == F_IDLE);
    assign a_ok   = (32'(atom_a) < MAX_ATOMS);
    assign b_ok   = (32'(atom_b) < MAX_ATOMS);
    assign addr_a = AW'(atom_a);
    assign addr_b = AW'(atom_b);
    assign wr_en  = accept && (func == FUNC_LOAD) && a_ok;
    assign rd_en  = accept && (func == FUNC_PAIR) && a_ok && b_ok;
    assign push   = (state_reg == F_PUSH) && !q_full;
    assign cmd    = cmd_reg;

    assign wa    = $signed(rd_a_reg[WEIGHT_W*k_reg +: WEIGHT_W]);
    assign wb    = $signed(rd_b_reg[WEIGHT_W*k_reg +: WEIGHT_W]);
    assign wprod = wa * wb;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wmem[addr_a] <= weights;
        end
        if (rd_en)
        begin
            rd_a_reg <= wmem[addr_a];
            rd_b_reg <= wmem[addr_b];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = F_MUL;
                    k_next     = 3'd0;
                end
                else if (accept && func == FUNC_FINISH)
                begin
                    state_next = F_PUSH;
                end
            end
            F_MUL:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'(NUM_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            k_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.finish   <= (func == FUNC_FINISH);
            cmd_reg.distance <= distance;
        end
        if (state_reg == F_MUL)
        begin
            cmd_reg.wprod[k_reg] <= wprod;
        end
    end

endmodule

`default_nettype wire

/* src/mspa_queue.sv */
// ----------------------------------------------------------------------------
// mspa_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mspa_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  mspa_pkg::cmd_t  wr_cmd,
    output logic            full,
    input  wire             pop,
    output mspa_pkg::cmd_t  head,
    output logic            empty
);
    import mspa_pkg::*;

    cmd_t       entry [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* src/mspa_back.sv */
// ----------------------------------------------------------------------------
// mspa_back
// per-scale sinc evaluation, saturating accumulation and result emission
// ----------------------------------------------------------------------------
`default_nettype none

module mspa_back #(
    parameter int NUM_SCALES = 32,
    parameter int SW         = 5
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  mspa_pkg::cmd_t       head,
    input  wire                  empty,
    output logic                 pop,
    output logic                 result_valid,
    output logic [SW-1:0]        scale_index,
    output mspa_pkg::res_t       sums,
    output logic                 final_scale
);
    import mspa_pkg::*;

    localparam int XW = SW + DIST_W;
    localparam int RW = XW + 6;

    localparam logic [4:0] B_IDLE = 5'd0;
    localparam logic [4:0] B_X    = 5'd1;
    localparam logic [4:0] B_T0   = 5'd2;
    localparam logic [4:0] B_T1   = 5'd3;
    localparam logic [4:0] B_Y0   = 5'd4;
    localparam logic [4:0] B_Y1   = 5'd5;
    localparam logic [4:0] B_Q0   = 5'd6;
    localparam logic [4:0] B_Q1   = 5'd7;
    localparam logic [4:0] B_D0   = 5'd8;
    localparam logic [4:0] B_D1   = 5'd9;
    localparam logic [4:0] B_H0   = 5'd10;
    localparam logic [4:0] B_H1   = 5'd11;
    localparam logic [4:0] B_S0   = 5'd12;
    localparam logic [4:0] B_S1   = 5'd13;
    localparam logic [4:0] B_DIV  = 5'd14;
    localparam logic [4:0] B_SGN  = 5'd15;
    localparam logic [4:0] B_RD   = 5'd16;
    localparam logic [4:0] B_LD   = 5'd17;
    localparam logic [4:0] B_A0   = 5'd18;
    localparam logic [4:0] B_A1   = 5'd19;
    localparam logic [4:0] B_WB   = 5'd20;
    localparam logic [4:0] B_CV   = 5'd21;

    logic [4:0]             state_reg, state_next;
    logic [SW-1:0]          s_reg;
    logic [2:0]             k_reg;
    logic [1:0]             d_idx_reg;
    logic [4:0]             cnt_reg;
    logic [NUM_SCALES-1:0]  row_valid_reg;
    logic                   res_valid_reg;
    logic                   final_reg;
    logic [SW-1:0]          scale_reg;
    res_t                   sums_reg;

    cmd_t                   cmd_reg;
    logic [XW-1:0]          x_reg;
    logic [30:0]            u_reg;
    logic                   neg_reg;
    logic [30:0]            y_reg;
    logic [31:0]            y2_reg;
    logic [31:0]            v_reg;
    logic [30:0]            c_reg;
    logic [RW-1:0]          rem_reg;
    logic [QW-1:0]          quo_reg;
    logic signed [SC_W-1:0] sc_reg;
    logic signed [65:0]     prod_reg;
    row_t                   row_reg;
    row_t                   rd_data_reg;
    row_t                   rmem [NUM_SCALES];

    logic signed [32:0]     mul_a, mul_b;
    logic [31:0]            t;
    logic [29:0]            u;
    logic [31:0]            q0, rem_c, qd;
    logic [31:0]            mag, n;
    logic [RW-1:0]          dv;
    logic [RW:0]            r2;
    logic                   ge;
    logic [SC_W-1:0]        sc_mag;
    logic signed [WPROD_W-1:0] p_sel;
    logic                   last_scale;
    logic                   trivial;
    logic                   rd_en, wr_en;

    assign pop          = (state_reg == B_IDLE) && !empty;
    assign last_scale   = (s_reg == SW'(NUM_SCALES - 1));
    assign trivial      = (s_reg == '0) || (cmd_reg.distance == '0);
    assign rd_en        = (state_reg == B_RD);
    assign wr_en        = (state_reg == B_WB);
    assign result_valid = res_valid_reg;
    assign scale_index  = scale_reg;
    assign sums         = sums_reg;
    assign final_scale  = final_reg;

    assign t      = prod_reg[39:8];
    assign u      = t[29:0];
    assign q0     = prod_reg[63:32];
    assign rem_c  = v_reg - 32'(q0 * 32'(div_const(d_idx_reg)));
    assign qd     = (rem_c >= 32'(div_const(d_idx_reg))) ? q0 + 32'd1 : q0;
    assign mag    = prod_reg[61:30];
    assign n      = mag + 32'({x_reg, 5'd0});
    assign dv     = {x_reg, 6'd0};
    assign r2     = {rem_reg, quo_reg[QW-1]};
    assign ge     = (r2 >= (RW+1)'(dv));
    assign sc_mag = {1'b0, quo_reg};
    assign p_sel  = (k_reg == 3'd0) ? PLAIN_WEIGHT
                                    : $signed(cmd_reg.wprod[3'(k_reg - 3'd1)]);

    // shared multiplier, operands by step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            B_T0:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'(INV_TWO_PI);
            end
            B_Y0:
            begin
                mul_a = 33'(u_reg);
                mul_b = 33'(HALF_PI);
            end
            B_Q0:
            begin
                mul_a = 33'(y_reg);
                mul_b = 33'(y_reg);
            end
            B_D0:
            begin
                mul_a = 33'(v_reg);
                mul_b = 33'(recip_const(d_idx_reg));
            end
            B_H0:
            begin
                mul_a = 33'(y2_reg);
                mul_b = 33'(c_reg);
            end
            B_S0:
            begin
                mul_a = 33'(y_reg);
                mul_b = 33'(c_reg);
            end
            B_A0:
            begin
                mul_a = 33'(p_sel);
                mul_b = 33'(sc_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: state_next = empty ? B_IDLE : (head.finish ? B_RD : B_X);
            B_X:    state_next = trivial ? B_RD : B_T0;
            B_T0:   state_next = B_T1;
            B_T1:   state_next = B_Y0;
            B_Y0:   state_next = B_Y1;
            B_Y1:   state_next = B_Q0;
            B_Q0:   state_next = B_Q1;
            B_Q1:   state_next = B_D0;
            B_D0:   state_next = B_D1;
            B_D1:   state_next = (d_idx_reg == 2'd3) ? B_S0 : B_H0;
            B_H0:   state_next = B_H1;
            B_H1:   state_next = B_D0;
            B_S0:   state_next = B_S1;
            B_S1:   state_next = B_DIV;
            B_DIV:  state_next = (cnt_reg == 5'(QW - 1)) ? B_SGN : B_DIV;
            B_SGN:  state_next = B_RD;
            B_RD:   state_next = B_LD;
            B_LD:   state_next = cmd_reg.finish ? B_CV : B_A0;
            B_A0:   state_next = B_A1;
            B_A1:   state_next = (k_reg == 3'(NUM_SUMS - 1)) ? B_WB : B_A0;
            B_WB:   state_next = last_scale ? B_IDLE : B_X;
            B_CV:   state_next = last_scale ? B_IDLE : B_RD;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            s_reg         <= '0;
            k_reg         <= 3'd0;
            d_idx_reg     <= 2'd0;
            cnt_reg       <= 5'd0;
            row_valid_reg <= '0;
            res_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    s_reg <= '0;
                end
                B_Q1:
                begin
                    d_idx_reg <= 2'd0;
                end
                B_H1:
                begin
                    d_idx_reg <= d_idx_reg + 2'd1;
                end
                B_S1:
                begin
                    cnt_reg <= 5'd0;
                end
                B_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                end
                B_LD:
                begin
                    k_reg <= 3'd0;
                end
                B_A1:
                begin
                    k_reg <= k_reg + 3'd1;
                end
                B_WB:
                begin
                    row_valid_reg[s_reg] <= 1'b1;
                    s_reg <= s_reg + SW'(1);
                end
                B_CV:
                begin
                    row_valid_reg[s_reg] <= 1'b0;
                    res_valid_reg <= 1'b1;
                    final_reg     <= last_scale;
                    s_reg <= s_reg + SW'(1);
                end
                default:
                begin
                    s_reg <= s_reg;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (rd_en)
        begin
            rd_data_reg <= rmem[s_reg];
        end
        if (wr_en)
        begin
            rmem[s_reg] <= row_reg;
        end
        case (state_reg)
            B_X:
            begin
                x_reg <= XW'(s_reg) * XW'(cmd_reg.distance);
                if (trivial)
                begin
                    sc_reg <= SINC_ONE;
                end
            end
            B_T1:
            begin
                u_reg   <= t[30] ? (Q30_ONE - 31'(u)) : 31'(u);
                neg_reg <= t[31];
            end
            B_Y1:
            begin
                y_reg <= prod_reg[60:30];
            end
            B_Q1:
            begin
                y2_reg <= prod_reg[61:30];
                v_reg  <= prod_reg[61:30];
            end
            B_D1:
            begin
                c_reg <= 31'(32'(Q30_ONE) - qd);
            end
            B_H1:
            begin
                v_reg <= prod_reg[61:30];
            end
            B_S1:
            begin
                rem_reg <= RW'(n[31:QW]);
                quo_reg <= n[QW-1:0];
            end
            B_DIV:
            begin
                rem_reg <= ge ? RW'(r2 - (RW+1)'(dv)) : RW'(r2);
                quo_reg <= {quo_reg[QW-2:0], ge};
            end
            B_SGN:
            begin
                sc_reg <= neg_reg ? $signed(SC_W'(0) - sc_mag) : $signed(sc_mag);
            end
            B_LD:
            begin
                row_reg <= row_valid_reg[s_reg] ? rd_data_reg : '0;
            end
            B_A1:
            begin
                row_reg[k_reg] <= sat_add(row_reg[k_reg], prod_reg[63:0]);
            end
            B_CV:
            begin
                scale_reg <= s_reg;
                for (int i = 0; i < NUM_SUMS; i++)
                begin
                    sums_reg[i] <= to_thousandths(row_reg[i]);
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        final_scale |-> (result_valid && scale_index == SW'(NUM_SCALES - 1)))
        else $error("final marker on wrong scale");
    a_emit_after_convert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CV) |=> result_valid)
        else $error("converted scale not emitted");
    a_emit_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(cmd_reg.finish))
        else $error("result emitted outside a finish");
`endif

endmodule

`default_nettype wire

/* src/morse_sinc_pair_accumulator_core.sv */
// ----------------------------------------------------------------------------
// morse_sinc_pair_accumulator_core
// molecular scattering descriptor accumulator over many scales
// ----------------------------------------------------------------------------
// usage:
//   a beat is taken when start is high and busy is low. func selects load
//   (write six weights of atom_a), pair (accumulate sinc(s*r) terms for
//   atom_a/atom_b at distance) or finish (emit and clear all sums).
//   load leaves busy low; pair holds busy while the weight products form
//   and until it moves to a two-entry command queue; finish holds busy
//   until it enters the queue. further beats are taken while the back end
//   works, until the queue is full.
//   the back end works through the scales of a pair one by one (skipping
//   the sinc steps when the sinc is trivially one), using the shared 33x33
//   multiplier and the 26-step radix-2 divider.
//   a finish emits one result per scale on result_valid, final_scale
//   marking the last; the receiver cannot stall, results are never held.
//   reset clears control state and marks all sums zero; the atom table is
//   undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_sinc_pair_accumulator_core #(
    parameter int MAX_ATOMS  = 256,
    parameter int NUM_SCALES = 32
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [1:0]                        func,
    input  wire  [7:0]                        atom_a,
    input  wire  [7:0]                        atom_b,
    input  wire  [15:0]                       distance,
    input  wire  signed [15:0]                w_mass,
    input  wire  signed [15:0]                w_vdw,
    input  wire  signed [15:0]                w_eneg,
    input  wire  signed [15:0]                w_pol,
    input  wire  signed [15:0]                w_ionpol,
    input  wire  signed [15:0]                w_istate,
    output logic                              result_valid,
    output logic [$clog2(NUM_SCALES)-1:0]     scale_index,
    output logic signed [47:0]                sum_plain,
    output logic signed [47:0]                sum_mass,
    output logic signed [47:0]                sum_vdw,
    output logic signed [47:0]                sum_eneg,
    output logic signed [47:0]                sum_pol,
    output logic signed [47:0]                sum_ionpol,
    output logic signed [47:0]                sum_istate,
    output logic                              final_scale
);
    import mspa_pkg::*;

    localparam int SW = $clog2(NUM_SCALES);

    logic [ENTRY_W-1:0] weights;
    cmd_t               f_cmd, q_head;
    logic               q_push, q_full, q_pop, q_empty;
    res_t               sums;

    assign weights = {w_istate, w_ionpol, w_pol, w_eneg, w_vdw, w_mass};

    mspa_front #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .atom_a   (atom_a),
        .atom_b   (atom_b),
        .distance (distance),
        .weights  (weights),
        .cmd      (f_cmd),
        .push     (q_push),
        .q_full   (q_full)
    );

    mspa_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_cmd (f_cmd),
        .full   (q_full),
        .pop    (q_pop),
        .head   (q_head),
        .empty  (q_empty)
    );

    mspa_back #(
        .NUM_SCALES (NUM_SCALES),
        .SW         (SW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .result_valid (result_valid),
        .scale_index  (scale_index),
        .sums         (sums),
        .final_scale  (final_scale)
    );

    assign sum_plain  = $signed(sums[0]);
    assign sum_mass   = $signed(sums[1]);
    assign sum_vdw    = $signed(sums[2]);
    assign sum_eneg   = $signed(sums[3]);
    assign sum_pol    = $signed(sums[4]);
    assign sum_ionpol = $signed(sums[5]);
    assign sum_istate = $signed(sums[6]);

endmodule

`default_nettype wire

/* test/morse_sinc_pair_accumulator_core_tb.sv */
// ----------------------------------------------------------------------------
// morse_sinc_pair_accumulator_core_tb
// self-checking bench for the scattering descriptor pair accumulator
// ----------------------------------------------------------------------------
// a directed set of loads, pairs, finishes and unused codes is followed by
// random molecules: weights are loaded, a few pairs of loaded atoms are
// accumulated and a finish emits the per-scale sums. a local fixed-point
// model of the sinc and the sums predicts every result beat, which the
// monitor compares field by field. start idles at random, but not from beat 120 to 174.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module morse_sinc_pair_accumulator_core_tb;
    import mspa_pkg::*;

    localparam int N_ATOMS  = 256;
    localparam int N_SCALES = 32;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        func_t            f;
        logic [7:0]       a;
        logic [7:0]       b;
        logic [15:0]      d;
        logic [5:0][15:0] w;
    } beat_t;

    typedef struct packed {
        logic [4:0]       scale;
        logic [6:0][47:0] sums;
        logic             last;
    } scale_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] func = '0;
    logic [7:0] atom_a = '0;
    logic [7:0] atom_b = '0;
    logic [15:0] distance = '0;
    logic signed [15:0] w_mass = '0, w_vdw = '0, w_eneg = '0;
    logic signed [15:0] w_pol = '0, w_ionpol = '0, w_istate = '0;
    logic busy, result_valid, final_scale;
    logic [4:0] scale_index;
    logic signed [47:0] sum_plain, sum_mass, sum_vdw, sum_eneg;
    logic signed [47:0] sum_pol, sum_ionpol, sum_istate;

    beat_t      pending_beats[$];
    scale_row_t expected_rows[$];
    logic signed [15:0] weight_table[N_ATOMS][6];
    logic signed [63:0] run_sums[N_SCALES][7];
    bit   loaded[N_ATOMS];
    int   loaded_list[$];
    int   errors = 0;
    int   accepted = 0;
    int   n_pairs = 0;
    int   n_finishes = 0;
    int   n_rows = 0;
    longint cycles = 0;

    morse_sinc_pair_accumulator_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .atom_a(atom_a), .atom_b(atom_b), .distance(distance),
        .w_mass(w_mass), .w_vdw(w_vdw), .w_eneg(w_eneg), .w_pol(w_pol),
        .w_ionpol(w_ionpol), .w_istate(w_istate), .result_valid(result_valid),
        .scale_index(scale_index), .sum_plain(sum_plain), .sum_mass(sum_mass),
        .sum_vdw(sum_vdw), .sum_eneg(sum_eneg), .sum_pol(sum_pol),
        .sum_ionpol(sum_ionpol), .sum_istate(sum_istate), .final_scale(final_scale)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic signed [63:0] sinc_fixed(input int s, input logic [15:0] r);
        logic [63:0] x, t, quad, u, y, y2, c, mag, q;
        if (s == 0 || r == 0)
        begin
            return 64'sd65536;
        end
        x = 64'(s) * 64'(r);
        t = ((x * 64'd683565276) >> 8) & 64'hFFFF_FFFF;
        quad = t >> 30;
        u = t & 64'h3FFF_FFFF;
        if (quad[0])
        begin
            u = 64'h4000_0000 - u;
        end
        y = (u * 64'd1686629713) >> 30;
        y2 = (y * y) >> 30;
        c = 64'h4000_0000 - y2 / 72;
        c = 64'h4000_0000 - ((y2 * c) >> 30) / 42;
        c = 64'h4000_0000 - ((y2 * c) >> 30) / 20;
        c = 64'h4000_0000 - ((y2 * c) >> 30) / 6;
        mag = (y * c) >> 30;
        q = (mag + x * 32) / (x * 64);
        return (quad >= 2) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    function automatic logic [47:0] milli_units(input logic signed [63:0] v);
        logic        neg;
        logic [63:0] m, res;
        neg = v[63];
        m = neg ? (64'd0 - v) : v;
        res = (m >> 36) * 1000 + (((m & 64'hF_FFFF_FFFF) * 1000 + (64'd1 << 35)) >> 36);
        if (neg)
        begin
            return (res > (64'd1 << 47)) ? 48'h8000_0000_0000 : 48'(64'd0 - res);
        end
        return (res > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : res[47:0];
    endfunction

    task automatic accumulate_beat(input beat_t bt);
        logic signed [63:0] prod[7];
        logic signed [63:0] sc;
        scale_row_t row;
        case (bt.f)
            FUNC_LOAD:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    weight_table[bt.a][i] = bt.w[i];
                end
            end
            FUNC_PAIR:
            begin
                n_pairs++;
                prod[0] = 64'sd1048576;
                for (int i = 0; i < 6; i++)
                begin
                    prod[i+1] = 64'(weight_table[bt.a][i]) * 64'(weight_table[bt.b][i]);
                end
                for (int s = 0; s < N_SCALES; s++)
                begin
                    sc = sinc_fixed(s, bt.d);
                    for (int k = 0; k < 7; k++)
                    begin
                        run_sums[s][k] = add_clamped(run_sums[s][k], prod[k] * sc);
                    end
                end
            end
            FUNC_FINISH:
            begin
                n_finishes++;
                for (int s = 0; s < N_SCALES; s++)
                begin
                    row.scale = 5'(s);
                    row.last = (s == N_SCALES - 1);
                    for (int k = 0; k < 7; k++)
                    begin
                        row.sums[k] = milli_units(run_sums[s][k]);
                        run_sums[s][k] = '0;
                    end
                    expected_rows.push_back(row);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_sum(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, $signed(exp_v), $signed(act_v));
            errors++;
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        bit idle;
        beat_t bt;
        idle = ($urandom_range(99) < 28) && !(accepted >= 120 && accepted < 175);
        if (rst_n && pending_beats.size() > 0 && !idle)
        begin
            bt = pending_beats[0];
            start <= 1'b1;
            func <= bt.f;
            atom_a <= bt.a;
            atom_b <= bt.b;
            distance <= bt.d;
            w_mass <= bt.w[0];
            w_vdw <= bt.w[1];
            w_eneg <= bt.w[2];
            w_pol <= bt.w[3];
            w_ionpol <= bt.w[4];
            w_istate <= bt.w[5];
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        scale_row_t row;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && start && !busy)
        begin
            accumulate_beat(pending_beats.pop_front());
            accepted++;
        end
        if (rst_n && result_valid)
        begin
            n_rows++;
            if (expected_rows.size() == 0)
            begin
                $error("result beat with no expectation, scale %0d", scale_index);
                errors++;
            end
            else
            begin
                row = expected_rows.pop_front();
                if (row.scale !== scale_index)
                begin
                    $error("scale_index expected %0d actual %0d", row.scale, scale_index);
                    errors++;
                end
                check_sum("sum_plain", row.sums[0], sum_plain);
                check_sum("sum_mass", row.sums[1], sum_mass);
                check_sum("sum_vdw", row.sums[2], sum_vdw);
                check_sum("sum_eneg", row.sums[3], sum_eneg);
                check_sum("sum_pol", row.sums[4], sum_pol);
                check_sum("sum_ionpol", row.sums[5], sum_ionpol);
                check_sum("sum_istate", row.sums[6], sum_istate);
                if (row.last !== final_scale)
                begin
                    $error("final_scale expected %0d actual %0d", row.last, final_scale);
                    errors++;
                end
            end
        end
    end

    function automatic beat_t load_beat(input int a, input logic [5:0][15:0] w);
        beat_t bt;
        bt = '0;
        bt.f = FUNC_LOAD;
        bt.a = 8'(a);
        bt.b = 8'($urandom);
        bt.d = 16'($urandom);
        bt.w = w;
        if (!loaded[a])
        begin
            loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
        return bt;
    endfunction

    function automatic beat_t pair_beat(input int a, input int b, input logic [15:0] d);
        beat_t bt;
        bt = '0;
        bt.f = FUNC_PAIR;
        bt.a = 8'(a);
        bt.b = 8'(b);
        bt.d = d;
        bt.w = {$urandom, $urandom, $urandom};
        return bt;
    endfunction

    function automatic beat_t plain_beat(input func_t f);
        beat_t bt;
        bt = '0;
        bt.f = f;
        bt.a = 8'($urandom);
        bt.b = 8'($urandom);
        bt.d = 16'($urandom);
        bt.w = {$urandom, $urandom, $urandom};
        return bt;
    endfunction

    function automatic logic [15:0] pick_distance();
        case ($urandom_range(3))
            0: return 16'($urandom_range(0, 255));
            1: return 16'($urandom_range(256, 2048));
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        int a, b, n_load, n_pair, total;
        for (int s = 0; s < N_SCALES; s++)
        begin
            for (int k = 0; k < 7; k++)
            begin
                run_sums[s][k] = '0;
            end
        end
        // directed
        pending_beats.push_back(plain_beat(FUNC_FINISH));
        pending_beats.push_back(load_beat(0, {6{16'h7FFF}}));
        pending_beats.push_back(load_beat(255, {6{16'h8000}}));
        pending_beats.push_back(load_beat(1, {16'h0000, 16'hFFFF, 16'h0001,
                                              16'h0400, 16'hFC00, 16'h7FFF}));
        pending_beats.push_back(load_beat(170, {16'h5555, 16'hAAAA, 16'h8000,
                                                16'h7FFF, 16'h0000, 16'h1234}));
        pending_beats.push_back(pair_beat(0, 0, 16'h0000));
        pending_beats.push_back(pair_beat(0, 255, 16'hFFFF));
        pending_beats.push_back(pair_beat(255, 255, 16'h0100));
        pending_beats.push_back(plain_beat(func_t'(2'd3)));
        pending_beats.push_back(pair_beat(1, 170, 16'h0001));
        pending_beats.push_back(plain_beat(FUNC_FINISH));
        pending_beats.push_back(pair_beat(170, 0, 16'h0324));
        pending_beats.push_back(pair_beat(1, 1, 16'h8000));
        pending_beats.push_back(plain_beat(func_t'(2'd3)));
        pending_beats.push_back(plain_beat(FUNC_FINISH));
        pending_beats.push_back(plain_beat(FUNC_FINISH));
        total = pending_beats.size();
        // random molecules
        while (total < 280)
        begin
            n_load = $urandom_range(1, 6);
            for (int i = 0; i < n_load; i++)
            begin
                pending_beats.push_back(load_beat($urandom_range(0, N_ATOMS - 1),
                                                  {$urandom, $urandom, $urandom}));
            end
            n_pair = $urandom_range(0, 3);
            for (int i = 0; i < n_pair; i++)
            begin
                a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                pending_beats.push_back(pair_beat(a, b, pick_distance()));
            end
            if ($urandom_range(9) == 0)
            begin
                pending_beats.push_back(plain_beat(func_t'(2'd3)));
            end
            pending_beats.push_back(plain_beat(FUNC_FINISH));
            total += n_load + n_pair + 1;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_beats.size() == 0 && expected_rows.size() == 0);
        repeat (300) @(posedge clk);
        $display("covered %0d beats: %0d pairs, %0d finishes, %0d result rows",
                 accepted, n_pairs, n_finishes, n_rows);
        if (errors == 0 && expected_rows.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
